// ===== rtl/ers_pkg.sv =====
`default_nettype none
package ers_pkg;

    localparam int HEADER_BYTES_DEF = 3;
    localparam int KEY_LEN = 12;
    localparam int HDR_CNT_W = 2;
    localparam int POS_W = 4;

    localparam logic [31:0] MAG_CAP = 32'h8000_0000;

    localparam logic [1:0] OUT_NOT_FOUND = 2'd0;
    localparam logic [1:0] OUT_FOUND = 2'd1;
    localparam logic [1:0] OUT_TRUNCATED = 2'd2;

    typedef struct packed {
        logic       is_expired;
        logic [1:0] outcome;
    } t_result;

    function automatic logic [7:0] key_char(input logic [POS_W-1:0] pos);
        logic [7:0] c;
        case (pos)
            4'd0:    c = "_";
            4'd1:    c = "_";
            4'd2:    c = "e";
            4'd3:    c = "x";
            4'd4:    c = "p";
            4'd5:    c = "i";
            4'd6:    c = "r";
            4'd7:    c = "e";
            4'd8:    c = "_";
            4'd9:    c = "K";
            4'd10:   c = "E";
            4'd11:   c = "Y";
            default: c = 8'h00;
        endcase
        return c;
    endfunction

endpackage
`default_nettype wire

// ===== rtl/expiry_record_scanner_core.sv =====
// Expiry record scanner.
// Input channel (i_valid/o_ready) carries one blob byte per request with
// i_last_byte marking the final byte. A byte is taken on every cycle in which
// both are high, so the sustained rate is one byte per cycle.
// Output channel (o_valid/i_ready) carries one result per blob, produced from
// the last byte: o_outcome is not found, found or truncated, and
// o_is_expired is set when the key was found and the current time exceeds it.
// The result is registered when the last byte is accepted and is held in
// a single output register until taken.
// While that register is full and i_ready is low, o_ready drops and input
// bytes wait; when the result is taken in the same cycle, input continues
// without a gap.
// The configuration channel (i_cfg_valid/o_cfg_ready) writes the current time
// and is always ready; it should be written only while no blob is in flight.
// Synchronous active-low reset clears the current time to zero, empties the
// output register and prepares the scanner for the start of a new blob.
`default_nettype none
module expiry_record_scanner_core #(
    parameter int HEADER_BYTES = ers_pkg::HEADER_BYTES_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire logic [7:0]  i_data_byte,
    input  wire logic        i_last_byte,
    output logic             o_valid,
    input  wire logic        i_ready,
    output logic             o_is_expired,
    output logic [1:0]       o_outcome,
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [31:0] i_cfg_data
);

    ers_pkg::t_result w_res;
    ers_pkg::t_result w_out;
    logic             w_load;
    logic             w_free;
    logic             w_fire;

    assign o_ready     = w_free;
    assign o_cfg_ready = 1'b1;
    assign w_fire      = i_valid && w_free;

    ers_parser #(
        .HEADER_BYTES(HEADER_BYTES)
    ) u_parser (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_data  (i_cfg_data),
        .i_fire      (w_fire),
        .i_data_byte (i_data_byte),
        .i_last_byte (i_last_byte),
        .o_res       (w_res),
        .o_res_load  (w_load)
    );

    ers_out_reg u_out_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (w_load),
        .i_res   (w_res),
        .i_ready (i_ready),
        .o_valid (o_valid),
        .o_free  (w_free),
        .o_res   (w_out)
    );

    assign o_is_expired = w_out.is_expired;
    assign o_outcome    = w_out.outcome;

endmodule
`default_nettype wire

// ===== rtl/ers_parser.sv =====
`default_nettype none
module ers_parser #(
    parameter int HEADER_BYTES = ers_pkg::HEADER_BYTES_DEF
) (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_cfg_valid,
    input  wire logic [31:0]     i_cfg_data,
    input  wire logic            i_fire,
    input  wire logic [7:0]      i_data_byte,
    input  wire logic            i_last_byte,
    output ers_pkg::t_result     o_res,
    output logic                 o_res_load
);

    typedef enum logic [2:0] {
        PH_HEADER, PH_NHI, PH_NLO, PH_NAME, PH_VHI, PH_VLO, PH_VALUE, PH_DONE
    } t_phase;

    typedef enum logic [1:0] {
        NS_SPACE, NS_DIGITS, NS_END
    } t_nstage;

    localparam t_phase START_PHASE = (HEADER_BYTES == 0) ? PH_NHI : PH_HEADER;
    localparam logic [ers_pkg::POS_W-1:0] KEY_END = ers_pkg::POS_W'(ers_pkg::KEY_LEN);

    t_phase                         r_phase, n_phase;
    logic [ers_pkg::HDR_CNT_W-1:0]  r_hdr_cnt, n_hdr_cnt;
    logic [15:0]                    r_rem, n_rem;
    logic [7:0]                     r_len_hi, n_len_hi;
    logic [ers_pkg::POS_W-1:0]      r_mpos, n_mpos;
    logic                           r_matching, n_matching;
    logic                           r_key_sel, n_key_sel;
    logic [31:0]                    r_acc, n_acc;
    t_nstage                        r_nstage, n_nstage;
    logic                           r_neg, n_neg;
    logic                           r_dec_made, n_dec_made;
    logic                           r_dec_exp, n_dec_exp;
    logic [31:0]                    r_cur_time;

    logic [15:0]        w_len;
    logic               w_digit;
    logic               w_space;
    logic [35:0]        w_mul;
    logic [31:0]        w_acc_next;
    logic signed [32:0] w_stamp;
    logic signed [32:0] w_now;
    logic [ers_pkg::HDR_CNT_W:0] w_hdr_inc;
    logic               w_trunc;

    assign w_len = {r_len_hi, i_data_byte};
    assign w_digit = (i_data_byte >= "0") && (i_data_byte <= "9");
    assign w_space = (i_data_byte == " ") || ((i_data_byte >= 8'd9) && (i_data_byte <= 8'd13));
    assign w_mul = ({4'b0, r_acc} << 3) + ({4'b0, r_acc} << 1)
                 + {32'b0, i_data_byte[3:0] - 4'h0};
    assign w_acc_next = (w_mul > {4'b0, ers_pkg::MAG_CAP}) ? ers_pkg::MAG_CAP : w_mul[31:0];
    assign w_stamp = r_neg ? -$signed({1'b0, r_acc})
                   : (r_acc[31] ? 33'sh0_7FFF_FFFF : $signed({1'b0, r_acc}));
    assign w_now = $signed({r_cur_time[31], r_cur_time});
    assign w_hdr_inc = {1'b0, r_hdr_cnt} + 1'b1;

    always_comb begin
        n_phase    = r_phase;
        n_hdr_cnt  = r_hdr_cnt;
        n_rem      = r_rem;
        n_len_hi   = r_len_hi;
        n_mpos     = r_mpos;
        n_matching = r_matching;
        n_key_sel  = r_key_sel;
        n_acc      = r_acc;
        n_nstage   = r_nstage;
        n_neg      = r_neg;
        n_dec_made = r_dec_made;
        n_dec_exp  = r_dec_exp;
        unique case (r_phase)
            PH_HEADER: begin
                n_hdr_cnt = w_hdr_inc[ers_pkg::HDR_CNT_W-1:0];
                if (32'(w_hdr_inc) >= 32'(HEADER_BYTES)) begin
                    n_phase = PH_NHI;
                end
            end
            PH_NHI: begin
                n_len_hi = i_data_byte;
                n_phase  = PH_NLO;
            end
            PH_VHI: begin
                n_len_hi = i_data_byte;
                n_phase  = PH_VLO;
            end
            PH_NLO: begin
                if (w_len == 16'd0) begin
                    n_phase = PH_DONE;
                end else begin
                    n_rem      = w_len;
                    n_mpos     = '0;
                    n_matching = 1'b1;
                    n_phase    = PH_NAME;
                end
            end
            PH_NAME: begin
                if (r_rem > 16'd1 && r_matching && r_mpos <= KEY_END) begin
                    if (i_data_byte == 8'd0) begin
                        if (r_mpos == KEY_END) begin
                            n_mpos = KEY_END + 1'b1;
                        end else begin
                            n_matching = 1'b0;
                        end
                    end else if (r_mpos < KEY_END && i_data_byte == ers_pkg::key_char(r_mpos)) begin
                        n_mpos = r_mpos + 1'b1;
                    end else begin
                        n_matching = 1'b0;
                    end
                end
                n_rem = r_rem - 16'd1;
                if (r_rem == 16'd1) begin
                    n_key_sel = r_matching && (r_mpos >= KEY_END);
                    n_phase   = PH_VHI;
                end
            end
            PH_VLO: begin
                n_acc    = '0;
                n_nstage = NS_SPACE;
                n_neg    = 1'b0;
                if (w_len == 16'd0) begin
                    if (r_key_sel) begin
                        n_dec_made = 1'b1;
                        n_dec_exp  = w_now > 33'sd0;
                        n_phase    = PH_DONE;
                    end else begin
                        n_phase = PH_NHI;
                    end
                end else begin
                    n_rem   = w_len;
                    n_phase = PH_VALUE;
                end
            end
            PH_VALUE: begin
                if (r_rem > 16'd1 && r_key_sel) begin
                    case (r_nstage)
                        NS_SPACE: begin
                            if (w_space) begin
                                n_nstage = NS_SPACE;
                            end else if (i_data_byte == "+" || i_data_byte == "-") begin
                                n_neg    = (i_data_byte == "-");
                                n_nstage = NS_DIGITS;
                            end else if (w_digit) begin
                                n_acc    = w_acc_next;
                                n_nstage = NS_DIGITS;
                            end else begin
                                n_nstage = NS_END;
                            end
                        end
                        NS_DIGITS: begin
                            if (w_digit) begin
                                n_acc = w_acc_next;
                            end else begin
                                n_nstage = NS_END;
                            end
                        end
                        default: begin
                            n_nstage = r_nstage;
                        end
                    endcase
                end
                n_rem = r_rem - 16'd1;
                if (r_rem == 16'd1) begin
                    if (r_key_sel) begin
                        n_dec_made = 1'b1;
                        n_dec_exp  = w_now > w_stamp;
                        n_phase    = PH_DONE;
                    end else begin
                        n_phase = PH_NHI;
                    end
                end
            end
            default: begin
                n_phase = r_phase;
            end
        endcase
    end

    assign w_trunc = (n_phase == PH_NAME) || (n_phase == PH_VHI)
                  || (n_phase == PH_VLO) || (n_phase == PH_VALUE);

    always_comb begin
        o_res_load = i_fire && i_last_byte;
        if (n_dec_made) begin
            o_res.is_expired = n_dec_exp;
            o_res.outcome    = ers_pkg::OUT_FOUND;
        end else if (w_trunc) begin
            o_res.is_expired = 1'b0;
            o_res.outcome    = ers_pkg::OUT_TRUNCATED;
        end else begin
            o_res.is_expired = 1'b0;
            o_res.outcome    = ers_pkg::OUT_NOT_FOUND;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur_time <= '0;
        end else if (i_cfg_valid) begin
            r_cur_time <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_fire && i_last_byte)) begin
            r_phase    <= START_PHASE;
            r_hdr_cnt  <= '0;
            r_rem      <= '0;
            r_len_hi   <= '0;
            r_mpos     <= '0;
            r_matching <= 1'b1;
            r_key_sel  <= 1'b0;
            r_acc      <= '0;
            r_nstage   <= NS_SPACE;
            r_neg      <= 1'b0;
            r_dec_made <= 1'b0;
            r_dec_exp  <= 1'b0;
        end else if (i_fire) begin
            r_phase    <= n_phase;
            r_hdr_cnt  <= n_hdr_cnt;
            r_rem      <= n_rem;
            r_len_hi   <= n_len_hi;
            r_mpos     <= n_mpos;
            r_matching <= n_matching;
            r_key_sel  <= n_key_sel;
            r_acc      <= n_acc;
            r_nstage   <= n_nstage;
            r_neg      <= n_neg;
            r_dec_made <= n_dec_made;
            r_dec_exp  <= n_dec_exp;
        end
    end

`ifndef NO_ASSERTIONS
    a_decision_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_dec_made |-> r_phase == PH_DONE)
        else $error("decision taken outside the done phase");
    a_mpos_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_mpos <= KEY_END + 1'b1)
        else $error("key match position out of range");
    a_acc_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_acc[31] |-> r_acc[30:0] == '0)
        else $error("accumulator above saturation cap");
`endif

endmodule
`default_nettype wire

// ===== rtl/ers_out_reg.sv =====
`default_nettype none
module ers_out_reg (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_load,
    input  ers_pkg::t_result      i_res,
    input  wire logic             i_ready,
    output logic                  o_valid,
    output logic                  o_free,
    output ers_pkg::t_result      o_res
);

    logic             r_valid;
    ers_pkg::t_result r_res;

    assign o_free  = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_res   = r_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_res <= i_res;
        end
    end

`ifndef NO_ASSERTIONS
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_load |-> o_free)
        else $error("result loaded over a pending result");
    a_expired_found: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && r_res.is_expired) |-> r_res.outcome == ers_pkg::OUT_FOUND)
        else $error("expired flag without a found key");
`endif

endmodule
`default_nettype wire
